// ===== design/assert_macros.svh =====
// Assertion macros shared by the keep-alive timeout table design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== design/ktt_pkg.sv =====
// Types, widths and codes of the keep-alive timeout table.
`timescale 1ns / 1ps
package ktt_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;

    localparam int ID_W       = 16;
    localparam int MODEL_W    = 3;
    localparam int TIME_W     = 48;
    localparam int LAST_W     = 49;
    localparam int SUM_W      = 50;
    localparam int DUR_W      = 16;
    localparam int INTERVAL_W = 32;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 32;

    localparam logic              CMD_ACTIVITY = 1'b0;
    localparam logic              CMD_TICK     = 1'b1;

    localparam logic [KIND_W-1:0] KIND_KEEPALIVE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACK       = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 32'd60000;
    localparam logic [DUR_W-1:0]      KA_DUR_RESET   = 16'd300;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MODEL_W-1:0] model;
        logic [LAST_W-1:0]  last;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } t_dp_cmd;

endpackage

// ===== design/ktt_ctrl.sv =====
// Sequencer of the keep-alive timeout table: accepts a transaction, scans and drains when enabled, finishes.
`timescale 1ns / 1ps
module ktt_ctrl #(
    parameter int TABLE_ENTRIES = ktt_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_enabled,
    output logic                 o_busy,
    output ktt_pkg::t_dp_cmd     o_cmd,
    output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] o_rd_addr
);
    import ktt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DRAIN1 = 3'd2;
    localparam logic [2:0] S_DRAIN2 = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [IDX_W-1:0] r_addr;
    logic [IDX_W-1:0] n_addr;
    t_dp_cmd          cmd;

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_addr   = '0;
                    n_state  = i_enabled ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                cmd.rd_en = 1'b1;
                if (r_addr == LAST_IDX) begin
                    n_state = S_DRAIN1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_FINISH;
            S_FINISH: begin
                cmd.finish = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_cmd     = cmd;
    assign o_rd_addr = r_addr;

endmodule

// ===== design/ktt_datapath.sv =====
// Datapath of the keep-alive timeout table: table memory, scan pipeline, results.
`timescale 1ns / 1ps
module ktt_datapath #(
    parameter int TABLE_ENTRIES = ktt_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ktt_pkg::t_dp_cmd                    i_cmd,
    input  logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] i_rd_addr,
    input  logic                                i_cfg_we,
    input  logic [ktt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ktt_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                i_command,
    input  logic [ktt_pkg::ID_W-1:0]            i_device_id,
    input  logic [ktt_pkg::MODEL_W-1:0]         i_model,
    input  logic [ktt_pkg::TIME_W-1:0]          i_now_ms,
    input  logic [ktt_pkg::DUR_W-1:0]           i_duration_ms,
    output logic                                o_enabled,
    output logic                                o_strobe,
    output logic [ktt_pkg::KIND_W-1:0]          o_kind,
    output logic [ktt_pkg::ID_W-1:0]            o_out_device_id,
    output logic [ktt_pkg::MODEL_W-1:0]         o_out_model,
    output logic [ktt_pkg::DUR_W-1:0]           o_send_duration_ms,
    output logic [ktt_pkg::INTERVAL_W-1:0]      o_sleep_ms,
    output logic                                o_table_full,
    output logic                                o_is_last
);
    import ktt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // configuration
    logic                  r_enabled;
    logic [INTERVAL_W-1:0] r_interval;
    logic [DUR_W-1:0]      r_ka_dur;

    // captured transaction
    logic               r_command;
    logic [ID_W-1:0]    r_id;
    logic [MODEL_W-1:0] r_model;
    logic [TIME_W-1:0]  r_now;
    logic [DUR_W-1:0]   r_dur;
    logic [LAST_W-1:0]  r_now_plus;
    logic [SUM_W-1:0]   r_earliest;

    // table
    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_rd_data;
    logic                     r_rd_vld;
    logic [IDX_W-1:0]         r_rd_idx;

    // activity search
    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;

    // tick stage B
    logic               r_b_vld;
    logic               r_b_due;
    logic [SUM_W-1:0]   r_b_dl;
    logic [ID_W-1:0]    r_b_id;
    logic [MODEL_W-1:0] r_b_model;
    logic [IDX_W-1:0]   r_b_idx;

    // output register
    logic                  r_strobe;
    logic [KIND_W-1:0]     r_kind;
    logic [ID_W-1:0]       r_out_id;
    logic [MODEL_W-1:0]    r_out_model;
    logic [DUR_W-1:0]      r_out_dur;
    logic [INTERVAL_W-1:0] r_out_sleep;
    logic                  r_out_full;
    logic                  r_out_last;

    logic                  is_tick;
    logic [LAST_W-1:0]     ld_now_plus;
    logic                  a_valid;
    logic [SUM_W-1:0]      a_sum;
    logic                  a_due;
    logic [SUM_W-1:0]      a_dl;
    logic                  slot_found;
    logic [IDX_W-1:0]      slot_idx;
    logic                  act_write;
    logic [LAST_W-1:0]     act_last;
    logic [SUM_W-1:0]      now_ext;
    logic [SUM_W-1:0]      sum_diff;
    logic [INTERVAL_W-1:0] slp;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    t_entry                wr_data;

    assign is_tick     = (r_command == CMD_TICK);
    assign ld_now_plus = {1'b0, i_now_ms} + {{(LAST_W - INTERVAL_W){1'b0}}, r_interval};
    assign now_ext     = {{(SUM_W - TIME_W){1'b0}}, r_now};

    // stage A: compare the read entry
    assign a_valid = r_valid[r_rd_idx];
    assign a_sum   = {1'b0, r_rd_data.last} + {{(SUM_W - INTERVAL_W){1'b0}}, r_interval};
    assign a_due   = a_valid && (a_sum < now_ext);
    assign a_dl    = a_due ? {1'b0, r_now_plus} : a_sum;

    // activity slot and summary
    assign slot_found = r_match_found | r_free_found;
    assign slot_idx   = r_match_found ? r_match_idx : r_free_idx;
    assign act_write  = i_cmd.finish && !is_tick && r_enabled && slot_found;
    assign act_last   = {1'b0, r_now} + {{(LAST_W - DUR_W){1'b0}}, r_dur};
    assign sum_diff   = r_earliest - now_ext;
    assign slp        = (r_earliest <= now_ext) ? '0 : sum_diff[INTERVAL_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_b_idx;
        wr_data = '{id: r_b_id, model: r_b_model, last: {1'b0, r_now}};
        if (act_write) begin
            wr_en   = 1'b1;
            wr_addr = slot_idx;
            wr_data = '{id: r_id, model: r_model, last: act_last};
        end else if (r_b_vld && r_b_due) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b1;
            r_interval <= INTERVAL_RESET;
            r_ka_dur   <= KA_DUR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:   r_enabled  <= i_cfg_wdata[0];
                CFG_INTERVAL: r_interval <= i_cfg_wdata[INTERVAL_W-1:0];
                CFG_DURATION: r_ka_dur   <= i_cfg_wdata[DUR_W-1:0];
                default:      r_enabled  <= r_enabled;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cfg_we && i_cfg_index == CFG_ENABLE && !i_cfg_wdata[0]) begin
            r_valid <= '0;
        end else if (act_write) begin
            r_valid[slot_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        r_rd_idx <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command  <= i_command;
            r_id       <= i_device_id;
            r_model    <= i_model;
            r_now      <= i_now_ms;
            r_dur      <= i_duration_ms;
            r_now_plus <= ld_now_plus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_earliest <= {1'b0, ld_now_plus};
        end else if (r_b_vld && r_b_dl < r_earliest) begin
            r_earliest <= r_b_dl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld      <= 1'b0;
            r_b_vld       <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            r_b_vld  <= r_rd_vld && is_tick && a_valid;
            if (i_cmd.load) begin
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
            end else if (r_rd_vld && !is_tick) begin
                if (a_valid && r_rd_data.id == r_id && !r_match_found) begin
                    r_match_found <= 1'b1;
                end
                if (!a_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld && !is_tick) begin
            if (a_valid && r_rd_data.id == r_id && !r_match_found) begin
                r_match_idx <= r_rd_idx;
            end
            if (!a_valid && !r_free_found) begin
                r_free_idx <= r_rd_idx;
            end
        end
        r_b_due   <= a_due;
        r_b_dl    <= a_dl;
        r_b_id    <= r_rd_data.id;
        r_b_model <= r_rd_data.model;
        r_b_idx   <= r_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish || (r_b_vld && r_b_due);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_last <= 1'b1;
            r_out_dur  <= '0;
            if (is_tick) begin
                r_kind      <= KIND_SUMMARY;
                r_out_id    <= '0;
                r_out_model <= '0;
                r_out_sleep <= r_enabled ? slp : r_interval;
                r_out_full  <= 1'b0;
            end else begin
                r_kind      <= KIND_ACK;
                r_out_id    <= r_id;
                r_out_model <= r_model;
                r_out_sleep <= '0;
                r_out_full  <= r_enabled && !slot_found;
            end
        end else if (r_b_vld && r_b_due) begin
            r_kind      <= KIND_KEEPALIVE;
            r_out_id    <= r_b_id;
            r_out_model <= r_b_model;
            r_out_dur   <= r_ka_dur;
            r_out_sleep <= '0;
            r_out_full  <= 1'b0;
            r_out_last  <= 1'b0;
        end
    end

    assign o_enabled          = r_enabled;
    assign o_strobe           = r_strobe;
    assign o_kind             = r_kind;
    assign o_out_device_id    = r_out_id;
    assign o_out_model        = r_out_model;
    assign o_send_duration_ms = r_out_dur;
    assign o_sleep_ms         = r_out_sleep;
    assign o_table_full       = r_out_full;
    assign o_is_last          = r_out_last;

endmodule

// ===== design/keepalive_timeout_table.sv =====
// Top level of the keep-alive timeout table.
// A transaction is taken when start is high and busy is low. With keep-alive
// enabled, every transaction (activity or tick) walks the whole table, one entry
// per cycle through the single read port of the table memory, and busy stays
// high through the scan, the drain states S_DRAIN1 and S_DRAIN2 and the finish
// state; the next transaction is taken once busy is low again. With keep-alive
// disabled a transaction skips the scan and goes straight to the finish state.
// Results appear on the o_ ports for one cycle each, marked by o_strobe, and
// cannot be held off: keep-alive results come while busy is high, at most one per
// cycle, and the acknowledgement or tick summary, with o_is_last set, appears in
// the cycle in which busy falls. Table state is not cleared after reset beyond
// its valid bits.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module keepalive_timeout_table #(
    parameter int TABLE_ENTRIES = ktt_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [ktt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ktt_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_command,
    input  logic [ktt_pkg::ID_W-1:0]       i_device_id,
    input  logic [ktt_pkg::MODEL_W-1:0]    i_model,
    input  logic [ktt_pkg::TIME_W-1:0]     i_now_ms,
    input  logic [ktt_pkg::DUR_W-1:0]      i_duration_ms,
    output logic                           o_strobe,
    output logic [ktt_pkg::KIND_W-1:0]     o_kind,
    output logic [ktt_pkg::ID_W-1:0]       o_out_device_id,
    output logic [ktt_pkg::MODEL_W-1:0]    o_out_model,
    output logic [ktt_pkg::DUR_W-1:0]      o_send_duration_ms,
    output logic [ktt_pkg::INTERVAL_W-1:0] o_sleep_ms,
    output logic                           o_table_full,
    output logic                           o_is_last
);
    import ktt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    t_dp_cmd          dp_cmd;
    logic [IDX_W-1:0] rd_addr;
    logic             enabled;

    ktt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_enabled (enabled),
        .o_busy    (busy),
        .o_cmd     (dp_cmd),
        .o_rd_addr (rd_addr)
    );

    ktt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .i_rd_addr          (rd_addr),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_command          (i_command),
        .i_device_id        (i_device_id),
        .i_model            (i_model),
        .i_now_ms           (i_now_ms),
        .i_duration_ms      (i_duration_ms),
        .o_enabled          (enabled),
        .o_strobe           (o_strobe),
        .o_kind             (o_kind),
        .o_out_device_id    (o_out_device_id),
        .o_out_model        (o_out_model),
        .o_send_duration_ms (o_send_duration_ms),
        .o_sleep_ms         (o_sleep_ms),
        .o_table_full       (o_table_full),
        .o_is_last          (o_is_last)
    );

    `ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_strobe && o_is_last, !busy)
    `ASSERT_IMP(a_ka_busy, i_clk, i_rst_n, o_strobe && !o_is_last, busy && o_kind == KIND_KEEPALIVE)
    `ASSERT_IMP(a_last_kind, i_clk, i_rst_n, o_strobe && o_is_last, o_kind == KIND_ACK || o_kind == KIND_SUMMARY)

endmodule
